[rtl/ordered_key_pair_roll_detector_macros.svh]
// Assertion macros for the ordered key pair roll detector.
`ifndef ORDERED_KEY_PAIR_ROLL_DETECTOR_MACROS_SVH
`define ORDERED_KEY_PAIR_ROLL_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF
`define OKPRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define OKPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define OKPRD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OKPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/okprd_pkg.sv]
// Shared types and codes for the ordered key pair roll detector.
package okprd_pkg;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2,
		OP_LOAD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_PASS    = 3'd0,
		ACT_COMBO   = 3'd1,
		ACT_PRESS   = 3'd2,
		ACT_RELEASE = 3'd3,
		ACT_TAP     = 3'd4
	} act_t;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

	typedef struct packed {
		logic latch;
		logic scan;
		logic decide;
		logic emit2;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_press;
		logic two_results;
	} sts_t;

endpackage

[rtl/okprd_ram.sv]
// Generic single write port RAM with registered read.
module okprd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/okprd_ctrl.sv]
// Controller state machine: accept, table scan, decision and result sequencing.
module okprd_ctrl import okprd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT2
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= sts.is_press ? ST_SCAN : ST_DECIDE;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:  state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= sts.two_results ? ST_EMIT2 : ST_IDLE;
				ST_EMIT2:  state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.latch  = start && (state_q == ST_IDLE);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.decide = (state_q == ST_DECIDE);
		cmd.emit2  = (state_q == ST_EMIT2);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/okprd_dp.sv]
// Datapath: item latch, pair table, scan compare, roll state and result registers.
module okprd_dp import okprd_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  operation,
	input  logic [15:0] keycode,
	input  logic [3:0]  entry_index,
	input  logic [15:0] entry_first,
	input  logic [15:0] entry_second,
	input  logic        entry_valid,
	output logic        result_strobe,
	output logic [2:0]  action,
	output logic [15:0] key_out,
	output logic [3:0]  match_index,
	output logic        last
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	op_t         op_q;
	logic [15:0] key_q;
	logic [3:0]  eidx_q;
	logic [15:0] efirst_q;
	logic [15:0] esecond_q;
	logic        evalid_q;

	logic [15:0] timeout_q;
	logic        in_roll_q;
	logic [15:0] held_q;
	logic [15:0] elapsed_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [AW-1:0]            cnt_q;
	logic                     rd_s1;
	logic                     valid_s1;
	logic [AW-1:0]            idx_s1;
	logic [31:0]              rdata;

	logic          first_hit_q;
	logic          pair_hit_q;
	logic [AW-1:0] pair_idx_q;

	logic        strobe_q;
	act_t        act_q;
	logic [15:0] kout_q;
	logic [3:0]  cidx_q;
	logic        last_q;
	act_t        pend_act_q;
	logic [15:0] pend_key_q;

	logic        load_we;
	logic        first_m;
	logic        pair_m;
	logic [15:0] elapsed_nx;
	logic        tmo;

	logic        r0_v;
	act_t        r0_act;
	logic [15:0] r0_key;
	logic [3:0]  r0_idx;
	logic        r1_v;
	act_t        r1_act;
	logic [15:0] r1_key;
	logic        roll_clr;
	logic        hold_set;
	logic        tick_upd;

	assign load_we = cmd.decide && (op_q == OP_LOAD) && (int'(eidx_q) < TABLE_ENTRIES);

	okprd_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (load_we),
		.waddr(AW'(eidx_q)),
		.wdata({efirst_q, esecond_q}),
		.re   (cmd.scan),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	assign first_m = rd_s1 && valid_s1 && (rdata[31:16] == key_q);
	assign pair_m  = rd_s1 && valid_s1 && (rdata[31:16] == held_q) && (rdata[15:0] == key_q);

	assign elapsed_nx = (elapsed_q == TICKS_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign tmo        = (elapsed_nx > timeout_q);

	always_comb begin
		r0_v     = 1'b0;
		r0_act   = ACT_PASS;
		r0_key   = key_q;
		r0_idx   = '0;
		r1_v     = 1'b0;
		r1_act   = ACT_PASS;
		r1_key   = key_q;
		roll_clr = 1'b0;
		hold_set = 1'b0;
		tick_upd = 1'b0;
		case (op_q)
			OP_PRESS: begin
				if (in_roll_q) begin
					roll_clr = 1'b1;
					r0_v     = 1'b1;
					if (pair_hit_q) begin
						r0_act = ACT_COMBO;
						r0_key = '0;
						r0_idx = 4'(pair_idx_q);
						r1_v   = 1'b1;
						r1_act = ACT_RELEASE;
						r1_key = held_q;
					end else begin
						r0_act = ACT_PRESS;
						r0_key = held_q;
						if (first_hit_q) begin
							hold_set = 1'b1;
						end else begin
							r1_v = 1'b1;
						end
					end
				end else if (first_hit_q) begin
					hold_set = 1'b1;
				end else begin
					r0_v = 1'b1;
				end
			end
			OP_RELEASE: begin
				r0_v = 1'b1;
				if (in_roll_q) begin
					roll_clr = 1'b1;
					r0_act   = ACT_TAP;
					r0_key   = held_q;
				end
			end
			OP_TICK: begin
				if (in_roll_q) begin
					tick_upd = 1'b1;
					if (tmo) begin
						roll_clr = 1'b1;
						r0_v     = 1'b1;
						r0_act   = ACT_PRESS;
						r0_key   = held_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			in_roll_q <= 1'b0;
			held_q    <= '0;
			elapsed_q <= '0;
			valid_q   <= '0;
			rd_s1     <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			rd_s1 <= cmd.scan;
			if (load_we) begin
				valid_q[AW'(eidx_q)] <= evalid_q;
			end
			if (cmd.decide) begin
				if (hold_set) begin
					in_roll_q <= 1'b1;
					held_q    <= key_q;
					elapsed_q <= '0;
				end else if (roll_clr) begin
					in_roll_q <= 1'b0;
				end
				if (tick_upd) begin
					elapsed_q <= elapsed_nx;
				end
			end
			strobe_q <= (cmd.decide && r0_v) || cmd.emit2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q        <= op_t'(operation);
			key_q       <= keycode;
			eidx_q      <= entry_index;
			efirst_q    <= entry_first;
			esecond_q   <= entry_second;
			evalid_q    <= entry_valid;
			cnt_q       <= '0;
			first_hit_q <= 1'b0;
			pair_hit_q  <= 1'b0;
			pair_idx_q  <= '0;
		end else begin
			if (cmd.scan) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (first_m) begin
				first_hit_q <= 1'b1;
			end
			if (pair_m && !pair_hit_q) begin
				pair_hit_q <= 1'b1;
				pair_idx_q <= idx_s1;
			end
		end
		if (cmd.scan) begin
			valid_s1 <= valid_q[cnt_q];
			idx_s1   <= cnt_q;
		end
		if (cmd.decide) begin
			act_q      <= r0_act;
			kout_q     <= r0_key;
			cidx_q     <= r0_idx;
			last_q     <= !r1_v;
			pend_act_q <= r1_act;
			pend_key_q <= r1_key;
		end else if (cmd.emit2) begin
			act_q  <= pend_act_q;
			kout_q <= pend_key_q;
			cidx_q <= '0;
			last_q <= 1'b1;
		end
	end

	always_comb begin
		sts             = '0;
		sts.scan_done   = (cnt_q == AW'(TABLE_ENTRIES - 1));
		sts.is_press    = (op_t'(operation) == OP_PRESS);
		sts.two_results = r1_v;
	end

	assign result_strobe = strobe_q;
	assign action        = act_q;
	assign key_out       = kout_q;
	assign match_index   = cidx_q;
	assign last          = last_q;

endmodule

[rtl/ordered_key_pair_roll_detector.sv]
// Top level of the ordered key pair roll detector.
// Busy stays high from the accepting edge until the item is done. A press item scans the
// pair table, one entry per cycle through the single read port of the pair table memory,
// then passes a drain state before its decision; release, tick and load items go straight
// to the decision, and two results add a second result state. Results come out on result_strobe for exactly
// one cycle each, back to back when an item gives two, and the receiver cannot stall
// them. The timeout register may be written at any time the block is not busy.
`include "ordered_key_pair_roll_detector_macros.svh"
module ordered_key_pair_roll_detector import okprd_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] keycode,
	input  logic [3:0]  entry_index,
	input  logic [15:0] entry_first,
	input  logic [15:0] entry_second,
	input  logic        entry_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        result_strobe,
	output logic [2:0]  action,
	output logic [15:0] key_out,
	output logic [3:0]  match_index,
	output logic        last
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	okprd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	okprd_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.keycode      (keycode),
		.entry_index  (entry_index),
		.entry_first  (entry_first),
		.entry_valid  (entry_valid),
		.entry_second (entry_second),
		.result_strobe(result_strobe),
		.action       (action),
		.key_out      (key_out),
		.match_index  (match_index),
		.last         (last)
	);

	`OKPRD_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`OKPRD_ASSERT_NEXT(a_second_beat, clk, arst_n, result_strobe && !last, result_strobe && last)
	`OKPRD_ASSERT_NEXT(a_combo_release, clk, arst_n, result_strobe && (action == ACT_COMBO), result_strobe && (action == ACT_RELEASE))
	`OKPRD_ASSERT_SAME(a_first_of_two, clk, arst_n, result_strobe && !last, busy)

endmodule
